### sv/hqr_pkg.sv
// shared types, codes and constants of the householder qr factoriser
package hqr_pkg;

   localparam int DATA_W  = 32;
   localparam int MUL_A_W = 33;
   localparam int NUM_W   = 34;
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int DIM_W   = 4;
   localparam int EPS_W   = 16;
   localparam int CSR_W   = 16;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_FACTOR = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] STATUS_READ  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_EPS  = 2'd2;

   localparam logic SEL_Q   = 1'b0;
   localparam logic PHASE_R = 1'b0;
   localparam logic PHASE_Q = 1'b1;

   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_QINIT,
      ST_STEP,
      ST_NRM_RD,
      ST_NRM_MUL,
      ST_NRM_ACC,
      ST_SQ1,
      ST_SQ1_WAIT,
      ST_P_MUL,
      ST_P_ACC,
      ST_SQ2_WAIT,
      ST_RF_RD,
      ST_RF_DIV,
      ST_RF_WAIT,
      ST_OUTER,
      ST_DOT_RD,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_DONE
   } state_type;

   function automatic logic [DATA_W-1:0] fx_mag(logic [DATA_W-1:0] x);
      return x[DATA_W-1] ? (~x + 1'b1) : x;
   endfunction

endpackage

### sv/hqr_mul.sv
// shared signed multiplier with registered product
module hqr_mul import hqr_pkg::*; #(
   parameter int A_W = 33,
   parameter int B_W = 36
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] prod
);

   logic signed [A_W+B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

### sv/hqr_isqrt.sv
// iterative integer square root, two radicand bits per cycle
module hqr_isqrt import hqr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] x_ff, x_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = radicand;
         res_in = '0;
         bit_in = RAD_W'(1) << (RAD_W - 2);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

### sv/hqr_fdiv.sv
// restoring fraction divider, one quotient bit per cycle, clamped to one
module hqr_fdiv import hqr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [NUM_W-1:0]     den,
   output logic                 done,
   output logic [FRAC_BITS:0]   quo
);

   localparam int CNT_W = $clog2(FRAC_BITS);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  den_ff, den_in;
   logic [FRAC_BITS:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [NUM_W:0]    shifted;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = den;
         cnt_in = '0;
         if (num >= den) begin
            q_in    = (FRAC_BITS+1)'(1) << FRAC_BITS;
            done_in = 1'b1;
         end else begin
            rem_in = num;
            q_in   = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = NUM_W'(shifted - {1'b0, den_ff});
            q_in   = {q_ff[FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in = shifted[NUM_W-1:0];
            q_in   = {q_ff[FRAC_BITS-1:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

### sv/householder_qr_factorizer_top.sv
// householder qr factoriser: sequencer, matrix stores and shared arithmetic
//
// usage
//  - req channel: a transaction is taken when start is high and busy is low.
//    req_kind selects load (write R element), factor, or read (Q or R element)
//  - a load gives no response; a read gives one response the cycle after it
//    is taken; a factor gives one response with status done when finished
//  - loads and reads are taken back to back, one per cycle
//  - a factor holds busy high for its whole run: Q is first set to
//    identity over rs by rs, then each step k with n = rs-k squares its
//    n entries, takes two square roots and the norm product, runs n
//    reflector divides and updates cs-k columns of R and rs rows of Q
//  - rsp_valid marks a response for exactly one cycle; the receiver cannot
//    stall, so the response must be taken in that cycle
//  - csr channel: rows in use, columns in use and the skip threshold, to be
//    written while idle (the block does not enforce this); csr_ready is always high
//  - reset returns the sizes to 8 by 8 and the threshold to 1, and marks all
//    of Q as zero; R holds whatever was loaded
module householder_qr_factorizer_top import hqr_pkg::*; #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_COLS  = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic                     req_which_matrix,
   input  logic [2:0]               req_row,
   input  logic [2:0]               req_col,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int IX_W    = $clog2(MAX_DIM + 1);
   localparam int RI_W    = $clog2(MAX_ROWS);
   localparam int R_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int Q_DEPTH = MAX_ROWS * MAX_ROWS;
   localparam int RA_W    = $clog2(R_DEPTH);
   localparam int QA_W    = $clog2(Q_DEPTH);
   localparam int DOT_W   = DATA_W + 1 + $clog2(MAX_ROWS);
   localparam int UPD_W   = DOT_W + 2;
   localparam int PROD_W  = MUL_A_W + DOT_W;
   localparam int REF_W   = FRAC_BITS + 2;
   localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

   // configuration registers
   logic [DIM_W-1:0] rows_used_ff;
   logic [DIM_W-1:0] cols_used_ff;
   logic [EPS_W-1:0] eps_ff;

   // sequencer state
   state_type              state_ff, state_in;
   logic [IX_W-1:0]        k_ff, k_in;
   logic [IX_W-1:0]        o_ff, o_in;
   logic [IX_W-1:0]        t_ff, t_in;
   logic                   phase_ff, phase_in;
   logic [RAD_W-1:0]       sumsq_ff, sumsq_in;
   logic [DATA_W-1:0]      x0_ff, x0_in;
   logic [NUM_W-1:0]       s_ff, s_in;
   logic [NUM_W-1:0]       d_ff, d_in;
   logic [ROOT_W-1:0]      norm_ff, norm_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic                   sign_ff, sign_in;
   logic signed [REF_W-1:0] refl_ff [MAX_ROWS];
   logic signed [REF_W-1:0] refl_in;
   logic                   refl_we;

   // read response pipeline
   logic rd_pend_ff, rd_oor_ff, rd_wm_ff;
   logic rd_pend_in, rd_oor_in;

   // matrix stores
   logic [DATA_W-1:0] r_mem [R_DEPTH];
   logic [DATA_W-1:0] q_mem [Q_DEPTH];
   logic [DATA_W-1:0] r_rdata_ff, q_rdata_ff;
   logic [Q_DEPTH-1:0] q_valid_ff;
   logic              q_rvalid_ff;
   logic [RA_W-1:0]   r_addr;
   logic [QA_W-1:0]   q_addr;
   logic              r_we, q_we;
   logic [DATA_W-1:0] r_wdata, q_wdata;

   // derived sizes
   logic [IX_W-1:0] rs, cs, steps, n_rows, o_end;
   logic            t_last, accept;

   // arithmetic units
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [DOT_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  prod, prod_sh;
   logic signed [DOT_W-1:0]   prod_t;
   logic                      sqrt_start, sqrt_done;
   logic [RAD_W-1:0]          sqrt_rad;
   logic [ROOT_W-1:0]         sqrt_root;
   logic                      div_start, div_done;
   logic [NUM_W-1:0]          div_num;
   logic [FRAC_BITS:0]        div_quo;

   // datapath helpers
   logic [DATA_W-1:0]        mem_data;
   logic signed [REF_W-1:0]  refl_t;
   logic [RAD_W:0]           sq_sum;
   logic [RAD_W-1:0]         p_sat;
   logic signed [UPD_W-1:0]  upd;
   logic [UPD_W-DATA_W:0]    upd_hi;
   logic [DATA_W-1:0]        upd_sat;
   logic                     root_skip;

   hqr_mul #(
      .A_W (MUL_A_W),
      .B_W (DOT_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   hqr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   hqr_fdiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_fdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (d_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // size clamping to the storage
   always_comb begin
      if (rows_used_ff == '0) rs = IX_W'(1);
      else if (int'(rows_used_ff) > MAX_ROWS) rs = IX_W'(MAX_ROWS);
      else rs = IX_W'(rows_used_ff);
      if (cols_used_ff == '0) cs = IX_W'(1);
      else if (int'(cols_used_ff) > MAX_COLS) cs = IX_W'(MAX_COLS);
      else cs = IX_W'(cols_used_ff);
      steps  = ((rs - 1'b1) < cs) ? (rs - 1'b1) : cs;
      n_rows = rs - k_ff;
      t_last = (t_ff == n_rows - 1'b1);
      o_end  = (phase_ff == PHASE_Q) ? rs : cs;
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // store addresses: the request in idle, the sequencer otherwise
   always_comb begin
      if (state_ff == ST_IDLE) begin
         r_addr = RA_W'(int'(req_row) * MAX_COLS + int'(req_col));
         q_addr = QA_W'(int'(req_row) * MAX_ROWS + int'(req_col));
      end else begin
         r_addr = RA_W'(int'(k_ff + t_ff) * MAX_COLS + int'(o_ff));
         q_addr = QA_W'(int'(o_ff) * MAX_ROWS + int'(k_ff + t_ff));
      end
   end

   // datapath
   always_comb begin
      mem_data = (phase_ff == PHASE_Q) ? (q_rvalid_ff ? q_rdata_ff : '0) : r_rdata_ff;
      refl_t   = refl_ff[t_ff[RI_W-1:0]];
      prod_sh  = prod >>> FRAC_BITS;
      prod_t   = prod_sh[DOT_W-1:0];
      sq_sum   = {1'b0, sumsq_ff} + {1'b0, prod[RAD_W-1:0]};
      p_sat    = (|prod[PROD_W-1:RAD_W]) ? '1 : prod[RAD_W-1:0];
      upd      = $signed({{(UPD_W-DATA_W){mem_data[DATA_W-1]}}, mem_data})
               - $signed({prod_t[DOT_W-1], prod_t, 1'b0});
      upd_hi   = upd[UPD_W-1:DATA_W-1];
      if (upd_hi == '0 || upd_hi == '1) upd_sat = upd[DATA_W-1:0];
      else upd_sat = upd[UPD_W-1] ? SAT_MIN : SAT_MAX;
      root_skip = (sqrt_root == '0) || (sqrt_root < ROOT_W'(eps_ff));
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      o_in       = o_ff;
      t_in       = t_ff;
      phase_in   = phase_ff;
      sumsq_in   = sumsq_ff;
      x0_in      = x0_ff;
      s_in       = s_ff;
      d_in       = d_ff;
      norm_in    = norm_ff;
      dot_in     = dot_ff;
      sign_in    = sign_ff;
      refl_we    = 1'b0;
      refl_in    = sign_ff ? -$signed(REF_W'(div_quo)) : $signed(REF_W'(div_quo));
      mul_a      = $signed({mem_data[DATA_W-1], mem_data});
      mul_b      = $signed({{(DOT_W-DATA_W){mem_data[DATA_W-1]}}, mem_data});
      sqrt_start = 1'b0;
      sqrt_rad   = sumsq_ff;
      div_start  = 1'b0;
      div_num    = (t_ff == '0) ? s_ff : NUM_W'(fx_mag(mem_data));
      r_we       = 1'b0;
      q_we       = 1'b0;
      r_wdata    = upd_sat;
      q_wdata    = upd_sat;
      rd_pend_in = accept && (req_kind == KIND_READ);
      if (req_which_matrix == SEL_Q)
         rd_oor_in = (int'(req_row) >= int'(rs)) || (int'(req_col) >= int'(rs));
      else
         rd_oor_in = (int'(req_row) >= int'(rs)) || (int'(req_col) >= int'(cs));

      case (state_ff)
         ST_IDLE: begin
            r_wdata = req_value;
            if (accept && req_kind == KIND_LOAD &&
                int'(req_row) < MAX_ROWS && int'(req_col) < MAX_COLS) begin
               r_we = 1'b1;
            end
            if (accept && req_kind == KIND_FACTOR) begin
               k_in     = '0;
               o_in     = '0;
               t_in     = '0;
               state_in = ST_QINIT;
            end
         end
         // identity into Q over rs by rs, column index rides on t
         ST_QINIT: begin
            q_we    = 1'b1;
            q_wdata = (o_ff == t_ff) ? FX_ONE : '0;
            if (t_ff == rs - 1'b1) begin
               t_in = '0;
               if (o_ff == rs - 1'b1) state_in = ST_STEP;
               else o_in = o_ff + 1'b1;
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         ST_STEP: begin
            if (k_ff == steps) begin
               state_in = ST_DONE;
            end else begin
               t_in     = '0;
               o_in     = k_ff;
               sumsq_in = '0;
               phase_in = PHASE_R;
               state_in = ST_NRM_RD;
            end
         end
         ST_NRM_RD: state_in = ST_NRM_MUL;
         ST_NRM_MUL: begin
            if (t_ff == '0) x0_in = mem_data;
            state_in = ST_NRM_ACC;
         end
         ST_NRM_ACC: begin
            sumsq_in = sq_sum[RAD_W] ? '1 : sq_sum[RAD_W-1:0];
            if (t_last) state_in = ST_SQ1;
            else begin
               t_in     = t_ff + 1'b1;
               state_in = ST_NRM_RD;
            end
         end
         ST_SQ1: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQ1_WAIT;
         end
         ST_SQ1_WAIT: begin
            if (sqrt_done) begin
               if (root_skip) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_STEP;
               end else begin
                  norm_in  = sqrt_root;
                  s_in     = NUM_W'(sqrt_root) + NUM_W'(fx_mag(x0_ff));
                  state_in = ST_P_MUL;
               end
            end
         end
         ST_P_MUL: begin
            mul_a    = $signed({1'b0, norm_ff});
            mul_b    = $signed(DOT_W'(s_ff));
            state_in = ST_P_ACC;
         end
         ST_P_ACC: begin
            sqrt_start = 1'b1;
            sqrt_rad   = p_sat >> 1;
            state_in   = ST_SQ2_WAIT;
         end
         ST_SQ2_WAIT: begin
            if (sqrt_done) begin
               if (root_skip) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_STEP;
               end else begin
                  d_in     = NUM_W'({sqrt_root, 1'b0});
                  t_in     = '0;
                  state_in = ST_RF_RD;
               end
            end
         end
         ST_RF_RD: state_in = ST_RF_DIV;
         // leading entry divides |x0|+norm, the rest divide their magnitude
         ST_RF_DIV: begin
            div_start = 1'b1;
            sign_in   = mem_data[DATA_W-1];
            state_in  = ST_RF_WAIT;
         end
         ST_RF_WAIT: begin
            if (div_done) begin
               refl_we = 1'b1;
               if (t_last) begin
                  t_in     = '0;
                  phase_in = PHASE_R;
                  state_in = ST_OUTER;
               end else begin
                  t_in     = t_ff + 1'b1;
                  state_in = ST_RF_RD;
               end
            end
         end
         // columns of R from k, then rows of Q from 0
         ST_OUTER: begin
            if (o_ff == o_end) begin
               if (phase_ff == PHASE_R) begin
                  phase_in = PHASE_Q;
                  o_in     = '0;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_STEP;
               end
            end else begin
               t_in     = '0;
               dot_in   = '0;
               state_in = ST_DOT_RD;
            end
         end
         ST_DOT_RD: state_in = ST_DOT_MUL;
         ST_DOT_MUL: begin
            mul_a    = $signed({{(MUL_A_W-REF_W){refl_t[REF_W-1]}}, refl_t});
            state_in = ST_DOT_ACC;
         end
         ST_DOT_ACC: begin
            dot_in = dot_ff + prod_t;
            if (t_last) begin
               t_in     = '0;
               state_in = ST_UPD_RD;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = ST_DOT_RD;
            end
         end
         ST_UPD_RD: begin
            mul_a    = $signed({{(MUL_A_W-REF_W){refl_t[REF_W-1]}}, refl_t});
            mul_b    = dot_ff;
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            if (phase_ff == PHASE_Q) q_we = 1'b1;
            else r_we = 1'b1;
            if (t_last) begin
               o_in     = o_ff + 1'b1;
               state_in = ST_OUTER;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = ST_UPD_RD;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rows_used_ff <= DIM_W'(8);
         cols_used_ff <= DIM_W'(8);
         eps_ff       <= EPS_W'(1);
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROWS: rows_used_ff <= csr_data[DIM_W-1:0];
               REG_COLS: cols_used_ff <= csr_data[DIM_W-1:0];
               REG_EPS:  eps_ff       <= csr_data[EPS_W-1:0];
               default:  ;
            endcase
         end
      end
      k_ff      <= k_in;
      o_ff      <= o_in;
      t_ff      <= t_in;
      phase_ff  <= phase_in;
      sumsq_ff  <= sumsq_in;
      x0_ff     <= x0_in;
      s_ff      <= s_in;
      d_ff      <= d_in;
      norm_ff   <= norm_in;
      dot_ff    <= dot_in;
      sign_ff   <= sign_in;
      rd_oor_ff <= rd_oor_in;
      rd_wm_ff  <= req_which_matrix;
      if (refl_we) refl_ff[t_ff[RI_W-1:0]] <= refl_in;
   end

   // R store, contents undefined until loaded
   always_ff @(posedge clock) begin
      if (r_we) r_mem[r_addr] <= r_wdata;
      r_rdata_ff <= r_mem[r_addr];
   end

   // Q store, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_addr] <= q_wdata;
      q_rdata_ff <= q_mem[q_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff  <= '0;
         q_rvalid_ff <= 1'b0;
      end else begin
         if (q_we) q_valid_ff[q_addr] <= 1'b1;
         q_rvalid_ff <= q_valid_ff[q_addr];
      end
   end

   // response: read transaction in the cycle after acceptance, or end of factor
   always_comb begin
      rsp_valid  = rd_pend_ff || (state_ff == ST_DONE);
      rsp_status = STATUS_READ;
      rsp_data   = '0;
      if (state_ff == ST_DONE) begin
         rsp_status = STATUS_DONE;
      end else if (rd_oor_ff) begin
         rsp_status = STATUS_RANGE;
      end else if (rd_wm_ff == SEL_Q) begin
         rsp_data = q_rvalid_ff ? q_rdata_ff : '0;
      end else begin
         rsp_data = r_rdata_ff;
      end
   end

endmodule
